FILE: design/tid_pkg.sv
// ----------------------------------------------------------------------------
// tid_pkg: shared types and constants for the tiled icon decoder
// Holds the palette geometry, port widths, the position record passed
// between the position counter and the top level, and the colour expansion.
// ----------------------------------------------------------------------------
package tid_pkg;

	// Default icon size in tiles along one side
	localparam int TILES_PER_SIDE_DEF = 4;

	// Pixels along one side of a tile, bytes along one tile row
	localparam int TILE_PIX  = 8;
	localparam int ROW_BYTES = 4;

	// Palette store geometry
	localparam int PAL_DEPTH = 16;
	localparam int PAL_AW    = $clog2(PAL_DEPTH);
	localparam int COLOR_W   = 15;

	// Field widths
	localparam int CMD_W   = 1;
	localparam int WORD_W  = 16;
	localparam int BYTE_W  = 8;
	localparam int NIB_W   = 4;
	localparam int POS_W   = 5;
	localparam int ARGB_W  = 32;

	// Stream data widths, padded to whole bytes
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 80;
	localparam int S_TUSER_W = 1;

	// Item kinds carried in tuser
	localparam logic [CMD_W-1:0] CMD_PALETTE = 1'b0;
	localparam logic [CMD_W-1:0] CMD_BITMAP  = 1'b1;

	// Opaque alpha byte
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// Position of one bitmap byte within the icon
	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
		logic             last;
	} pos_t;

	// BGR555 to ARGB8888: each 5-bit channel moves up by 3, alpha opaque
	function automatic logic [ARGB_W-1:0] to_argb(input logic [COLOR_W-1:0] w);
		to_argb = {ALPHA_OPAQUE, w[4:0], 3'b000, w[9:5], 3'b000, w[14:10], 3'b000};
	endfunction

endpackage

FILE: design/tid_ram.sv
// ----------------------------------------------------------------------------
// tid_ram: generic RAM, one write port, two registered read ports
// Read data is loaded on rd_en and holds otherwise.
// ----------------------------------------------------------------------------
module tid_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem[rd_addr_a];
			rd_data_b <= mem[rd_addr_b];
		end
	end

endmodule

FILE: design/tid_pos.sv
// ----------------------------------------------------------------------------
// tid_pos: tile-ordered position counter
// Counts bitmap bytes as byte-in-row, row-in-tile, tile column and tile row,
// giving the x,y of the current byte and flagging the final byte of the icon.
// ----------------------------------------------------------------------------
module tid_pos #(
	parameter int TILES_PER_SIDE = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          advance,
	output tid_pkg::pos_t pos
);

	import tid_pkg::*;

	localparam int TW = (TILES_PER_SIDE > 1) ? $clog2(TILES_PER_SIDE) : 1;
	localparam int LXW = $clog2(ROW_BYTES);
	localparam int LYW = $clog2(TILE_PIX);
	localparam logic [TW-1:0]  T_MAX  = TW'(TILES_PER_SIDE - 1);
	localparam logic [LXW-1:0] LX_MAX = LXW'(ROW_BYTES - 1);
	localparam logic [LYW-1:0] LY_MAX = LYW'(TILE_PIX - 1);

	logic [LXW-1:0] lx_q;
	logic [LYW-1:0] ly_q;
	logic [TW-1:0]  tx_q;
	logic [TW-1:0]  ty_q;
	logic           row_end;
	logic           tile_end;
	logic           trow_end;
	logic [TW+LXW:0]  x_full;
	logic [TW+LYW-1:0] y_full;

	// Wrap points of each counter
	assign row_end  = (lx_q == LX_MAX);
	assign tile_end = row_end && (ly_q == LY_MAX);
	assign trow_end = tile_end && (tx_q == T_MAX);

	// Counters, one byte per advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lx_q <= '0;
			ly_q <= '0;
			tx_q <= '0;
			ty_q <= '0;
		end else if (advance) begin
			lx_q <= lx_q + 1'b1;
			if (row_end) begin
				ly_q <= ly_q + 1'b1;
			end
			if (tile_end) begin
				tx_q <= (tx_q == T_MAX) ? '0 : tx_q + 1'b1;
			end
			if (trow_end) begin
				ty_q <= (ty_q == T_MAX) ? '0 : ty_q + 1'b1;
			end
		end
	end

	// x = tile column * 8 + byte * 2, y = tile row * 8 + row; low bits kept
	assign x_full   = {tx_q, lx_q, 1'b0};
	assign y_full   = {ty_q, ly_q};
	assign pos.x    = POS_W'(x_full);
	assign pos.y    = POS_W'(y_full);
	assign pos.last = trow_end && (ty_q == T_MAX);

	// After the final byte the position starts over at the origin
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		advance && pos.last |=> pos.x == '0 && pos.y == '0)
		else $error("position did not wrap after final byte");

endmodule

FILE: design/tiled_4bpp_icon_palette_decoder.sv
// ----------------------------------------------------------------------------
// tiled_4bpp_icon_palette_decoder: 4bpp tiled icon to ARGB8888 decoder
// Palette writes fill a 16-entry BGR555 store; bitmap bytes are expanded to
// two ARGB8888 pixels with their tile-ordered position.
// ----------------------------------------------------------------------------
// One item is taken per clock cycle while the output register is empty or
// being taken by the sink: the palette RAM is read at the accept edge and the
// result appears in the output register on the next cycle, held there until
// the sink takes it while a new item is accepted in the same cycle. Palette
// writes give no result. The palette reads as all zero from reset through
// per-entry valid bits, so no clearing pass is needed and the block is ready
// straight after reset. An index of zero always yields a transparent pixel.
module tiled_4bpp_icon_palette_decoder #(
	parameter int TILES_PER_SIDE = tid_pkg::TILES_PER_SIDE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// palette_index[3:0], color_word[19:4], pixel_byte[27:20], zero [31:28]
	input  logic [tid_pkg::S_TDATA_W-1:0]  s_tdata,
	// cmd[0]
	input  logic [tid_pkg::S_TUSER_W-1:0]  s_tuser,
	// Output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// pos_x[4:0], pos_y[9:5], left_argb[41:10], right_argb[73:42], zero [79:74]
	output logic [tid_pkg::M_TDATA_W-1:0]  m_tdata,
	output logic                           m_tlast
);

	import tid_pkg::*;

	logic                 accept;
	logic                 pal_we;
	logic                 pix_re;
	logic [PAL_AW-1:0]    pal_index;
	logic [COLOR_W-1:0]   pal_color;
	logic [BYTE_W-1:0]    pix_byte;
	logic [NIB_W-1:0]     nib_l;
	logic [NIB_W-1:0]     nib_r;
	logic [PAL_DEPTH-1:0] pal_valid_q;
	logic [COLOR_W-1:0]   color_l;
	logic [COLOR_W-1:0]   color_r;
	logic [ARGB_W-1:0]    argb_l;
	logic [ARGB_W-1:0]    argb_r;
	pos_t                 pos;
	pos_t                 pos_s1;
	logic                 valid_s1;
	logic                 show_l_s1;
	logic                 show_r_s1;
	logic                 nz_l_s1;
	logic                 nz_r_s1;

	// Field unpacking
	assign pal_index = s_tdata[PAL_AW-1:0];
	assign pal_color = s_tdata[PAL_AW +: COLOR_W];
	assign pix_byte  = s_tdata[PAL_AW + WORD_W +: BYTE_W];
	assign nib_l     = pix_byte[NIB_W-1:0];
	assign nib_r     = pix_byte[BYTE_W-1:NIB_W];

	// Handshake: a new transaction is taken whenever the output register frees
	assign s_tready = !valid_s1 || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign pal_we   = accept && (s_tuser[0] == CMD_PALETTE);
	assign pix_re   = accept && (s_tuser[0] == CMD_BITMAP);

	// Palette store
	tid_ram #(
		.WIDTH (COLOR_W),
		.DEPTH (PAL_DEPTH)
	) u_pal_ram (
		.clk       (clk),
		.wr_en     (pal_we),
		.wr_addr   (pal_index),
		.wr_data   (pal_color),
		.rd_en     (pix_re),
		.rd_addr_a (nib_l),
		.rd_addr_b (nib_r),
		.rd_data_a (color_l),
		.rd_data_b (color_r)
	);

	// Written flags: an entry not yet written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pal_valid_q <= '0;
		end else if (pal_we) begin
			pal_valid_q[pal_index] <= 1'b1;
		end
	end

	// Position of the incoming bitmap byte
	tid_pos #(
		.TILES_PER_SIDE (TILES_PER_SIDE)
	) u_pos (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (pix_re),
		.pos     (pos)
	);

	// Output register: valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= pix_re;
		end
	end

	// Output register: position and per-pixel masks
	always_ff @(posedge clk) begin
		if (pix_re) begin
			pos_s1    <= pos;
			show_l_s1 <= (nib_l != '0) && pal_valid_q[nib_l];
			show_r_s1 <= (nib_r != '0) && pal_valid_q[nib_r];
		end
	end

	// Nonzero index of the held result, kept alongside the masks
	always_ff @(posedge clk) begin
		if (pix_re) begin
			nz_l_s1 <= (nib_l != '0);
			nz_r_s1 <= (nib_r != '0);
		end
	end

	// Colour expansion; index zero is transparent, an unwritten nonzero
	// entry is opaque black
	always_comb begin
		argb_l = '0;
		argb_r = '0;
		if (show_l_s1) begin
			argb_l = to_argb(color_l);
		end else if (nz_l_s1) begin
			argb_l = to_argb('0);
		end
		if (show_r_s1) begin
			argb_r = to_argb(color_r);
		end else if (nz_r_s1) begin
			argb_r = to_argb('0);
		end
	end

	// Output packing
	assign m_tvalid = valid_s1;
	assign m_tlast  = pos_s1.last;
	assign m_tdata  = {(M_TDATA_W - 2*POS_W - 2*ARGB_W)'(0), argb_r, argb_l,
		pos_s1.y, pos_s1.x};

	// A bitmap byte always produces a result on the next cycle
	a_bitmap_result: assert property (@(posedge clk) disable iff (!arst_n)
		pix_re |=> m_tvalid)
		else $error("bitmap byte gave no result");

	// A palette write into an empty output stage produces no result
	a_palette_silent: assert property (@(posedge clk) disable iff (!arst_n)
		pal_we && !valid_s1 |=> !m_tvalid)
		else $error("palette write produced a result");

	// A written palette entry is marked as written
	a_pal_marked: assert property (@(posedge clk) disable iff (!arst_n)
		pal_we |=> pal_valid_q[$past(pal_index)])
		else $error("palette entry not marked after write");

endmodule
